// ----- design/swh_pkg.sv -----
// Package for the shallow-water HLLC flux pipeline: payload types,
// register codes and saturating Q16.16 helpers. No dependencies.
`default_nettype none
package swh_pkg;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		logic        [30:0] height_left;
		logic signed [31:0] vel_x_left;
		logic signed [31:0] vel_y_left;
		logic        [30:0] height_right;
		logic signed [31:0] vel_x_right;
		logic signed [31:0] vel_y_right;
	} swh_in_t;

	typedef struct packed {
		logic signed [31:0] flux_mass;
		logic signed [31:0] flux_momentum_x;
		logic signed [31:0] flux_momentum_y;
		logic        [30:0] wave_speed;
	} swh_out_t;

	// per-interface values carried alongside the long arithmetic units
	typedef struct packed {
		q_t   h_l;
		q_t   h_r;
		q_t   u_l;
		q_t   u_r;
		q_t   v_l;
		q_t   v_r;
		q_t   q_l;
		q_t   q_r;
		q_t   p_l;
		q_t   p_r;
		q_t   dh;
		q_t   dq;
		logic dry_l;
		logic dry_r;
	} swh_side_t;

	typedef struct packed {
		logic        den_zero;
		logic        cden_nz;
		logic [30:0] wave;
	} swh_mid_t;

	localparam logic [1:0] CFG_DRY_THRESHOLD   = 2'd0;
	localparam logic [1:0] CFG_GRAVITY         = 2'd1;
	localparam logic [1:0] CFG_CONTACT_EPSILON = 2'd2;

	localparam logic [30:0] DRY_THRESHOLD_RST   = 31'd1;
	localparam logic [30:0] GRAVITY_RST         = 31'd642908;
	localparam q_t          CONTACT_EPSILON_RST = 32'sd0;

	localparam q_t Q_ONE  = 32'sd65536;
	localparam q_t Q_HALF = 32'sd32768;
	localparam q_t Q_MAX  = 32'sh7fffffff;
	localparam q_t Q_MIN  = 32'sh80000000;
	localparam q_t Q_ZERO = 32'sd0;

	// root bits and root bits resolved per stage
	localparam int SQRT_BITS  = 24;
	localparam int SQRT_STEPS = 4;
	// quotient bits and quotient bits resolved per stage
	localparam int DIV_BITS   = 48;
	localparam int DIV_STEPS  = 8;

	function automatic q_t sat64(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return Q_MAX;
		else if (x < -64'sd2147483648)
			return Q_MIN;
		else
			return x[31:0];
	endfunction

	function automatic q_t sat33(input logic signed [32:0] s);
		if (s[32] != s[31])
			return s[32] ? Q_MIN : Q_MAX;
		else
			return s[31:0];
	endfunction

	function automatic q_t qadd(input q_t a, input q_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return sat33(s);
	endfunction

	function automatic q_t qsub(input q_t a, input q_t b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		return sat33(s);
	endfunction

	function automatic q_t qabs(input q_t a);
		if (a == Q_MIN)
			return Q_MAX;
		else
			return a[31] ? -a : a;
	endfunction

	function automatic q_t qmin(input q_t a, input q_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic q_t qmax(input q_t a, input q_t b);
		return (a > b) ? a : b;
	endfunction

	// round to nearest, ties up: floor((a*b + 2^15) / 2^16)
	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [63:0] aw;
		logic signed [63:0] bw;
		logic signed [63:0] p;
		aw = 64'(a);
		bw = 64'(b);
		p  = aw * bw + 64'sd32768;
		return sat64(p >>> 16);
	endfunction

	function automatic q_t from_height(input logic [30:0] h);
		return q_t'({1'b0, h});
	endfunction

endpackage
`default_nettype wire

// ----- design/swh_delay.sv -----
// Stall-aware delay line for sideband values of the flux pipeline.
// Depends on nothing.
`default_nettype none
module swh_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] pipe_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= din;
			for (int i = 1; i < N; i++)
				pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign dout = pipe_q[N-1];

endmodule
`default_nettype wire

// ----- design/swh_sqrt.sv -----
// Pipelined floor(sqrt(x * 2^16)) for non-negative Q16.16 values.
// Depends on swh_pkg.
`default_nettype none
module swh_sqrt
	import swh_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire q_t                   x,
	output logic      [SQRT_BITS-1:0] root
);

	localparam int NS = SQRT_BITS / SQRT_STEPS;
	localparam int VW = 2 * SQRT_BITS;
	localparam int RW = SQRT_BITS + 2;

	logic [RW-1:0]        rem_q  [NS];
	logic [SQRT_BITS-1:0] root_q [NS];
	logic [VW-1:0]        v_q    [NS];

	logic [RW-1:0]        rem_d  [NS];
	logic [SQRT_BITS-1:0] root_d [NS];
	logic [VW-1:0]        v_d    [NS];

	logic [VW-1:0] v_in;

	assign v_in = (x <= 0) ? '0 : VW'({x, 16'b0});

	always_comb begin
		logic [RW-1:0]        r;
		logic [SQRT_BITS-1:0] s;
		logic [VW-1:0]        v;
		logic [RW+1:0]        t;
		logic [RW+1:0]        trial;
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				r = '0;
				s = '0;
				v = v_in;
			end else begin
				r = rem_q[k-1];
				s = root_q[k-1];
				v = v_q[k-1];
			end
			for (int j = 0; j < SQRT_STEPS; j++) begin
				t     = {r, v[VW-1 -: 2]};
				trial = (RW+2)'({s, 2'b01});
				if (t >= trial) begin
					r = RW'(t - trial);
					s = {s[SQRT_BITS-2:0], 1'b1};
				end else begin
					r = RW'(t);
					s = {s[SQRT_BITS-2:0], 1'b0};
				end
				v = {v[VW-3:0], 2'b00};
			end
			rem_d[k]  = r;
			root_d[k] = s;
			v_d[k]    = v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rem_q[k]  <= rem_d[k];
				root_q[k] <= root_d[k];
				v_q[k]    <= v_d[k];
			end
		end
	end

	assign root = root_q[NS-1];

endmodule
`default_nettype wire

// ----- design/swh_div.sv -----
// Pipelined saturating Q16.16 quotient (a * 2^16) / b, truncated toward
// zero; a zero divisor gives zero. Depends on swh_pkg.
`default_nettype none
module swh_div
	import swh_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire q_t   num,
	input  wire q_t   den,
	output q_t        quo
);

	localparam int NS = DIV_BITS / DIV_STEPS;

	// index 0 is the operand stage, 1..NS the iteration stages
	logic [32:0]         rem_q [NS+1];
	logic [DIV_BITS-1:0] nq_q  [NS+1];
	logic [31:0]         d_q   [NS+1];
	logic                neg_q [NS+1];
	logic                bz_q  [NS+1];

	logic [32:0]         rem_d [NS];
	logic [DIV_BITS-1:0] nq_d  [NS];

	logic [31:0] abs_n;
	logic [31:0] abs_d;
	q_t          quo_d;

	assign abs_n = num[31] ? (~num + 32'd1) : num;
	assign abs_d = den[31] ? (~den + 32'd1) : den;

	always_comb begin
		logic [32:0]         r;
		logic [DIV_BITS-1:0] n;
		logic [32:0]         t;
		for (int k = 0; k < NS; k++) begin
			r = rem_q[k];
			n = nq_q[k];
			for (int j = 0; j < DIV_STEPS; j++) begin
				t = {r[31:0], n[DIV_BITS-1]};
				if (t >= {1'b0, d_q[k]}) begin
					r = t - {1'b0, d_q[k]};
					n = {n[DIV_BITS-2:0], 1'b1};
				end else begin
					r = t;
					n = {n[DIV_BITS-2:0], 1'b0};
				end
			end
			rem_d[k] = r;
			nq_d[k]  = n;
		end
	end

	always_comb begin
		logic [DIV_BITS-1:0] qm;
		qm = nq_q[NS];
		if (bz_q[NS])
			quo_d = Q_ZERO;
		else if (!neg_q[NS])
			quo_d = (qm > DIV_BITS'(32'h7fffffff)) ? Q_MAX : q_t'(qm[31:0]);
		else
			quo_d = (qm > DIV_BITS'(32'h80000000)) ? Q_MIN : -q_t'(qm[31:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			nq_q[0]  <= DIV_BITS'({abs_n, 16'b0});
			d_q[0]   <= abs_d;
			neg_q[0] <= num[31] ^ den[31];
			bz_q[0]  <= (den == Q_ZERO);
			for (int k = 0; k < NS; k++) begin
				rem_q[k+1] <= rem_d[k];
				nq_q[k+1]  <= nq_d[k];
				d_q[k+1]   <= d_q[k];
				neg_q[k+1] <= neg_q[k];
				bz_q[k+1]  <= bz_q[k];
			end
			quo <= quo_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/shallow_water_hllc_flux_top.sv -----
// Top level of the shallow-water HLLC interface flux pipeline.
// Depends on swh_pkg, swh_delay, swh_sqrt and swh_div.
//
//  channel | signals                                  | direction | transfer when
//  --------+------------------------------------------+-----------+-------------------
//  in      | in_valid, in_stall, in_data              | sink      | valid & !stall
//  out     | out_valid, out_stall, out_data           | source    | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink      | valid & ready
//
// One interface enters per cycle unless the output stalls; results leave in
// input order. The depth is set by the 6-stage square root and the
// 8-stage dividers (8 quotient bits per stage) in series.
// Reset clears the valid bits and loads the register defaults.
// A stall on the output freezes the whole pipeline, so nothing is lost or
// repeated; cfg_ready is always high.
`default_nettype none
module shallow_water_hllc_flux_top
	import swh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire swh_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output swh_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int SQRT_LAT = SQRT_BITS / SQRT_STEPS;
	localparam int DIV_LAT  = DIV_BITS / DIV_STEPS + 2;
	// stage holding the root; side values join at stage 4
	localparam int ST_SQRT  = 2 + SQRT_LAT;
	localparam int ST_DIVI  = ST_SQRT + 5;
	localparam int ST_DIVO  = ST_DIVI + DIV_LAT;
	localparam int ST_OUT   = ST_DIVO + 4;
	localparam int SIDE_W   = $bits(swh_side_t);
	localparam int MID_W    = $bits(swh_mid_t);

	// ---------------- configuration registers ----------------
	logic [30:0] dry_thr_q;
	logic [30:0] gravity_q;
	q_t          eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_thr_q <= DRY_THRESHOLD_RST;
			gravity_q <= GRAVITY_RST;
			eps_q     <= CONTACT_EPSILON_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DRY_THRESHOLD:   dry_thr_q <= cfg_data[30:0];
				CFG_GRAVITY:         gravity_q <= cfg_data[30:0];
				CFG_CONTACT_EPSILON: eps_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic              adv;
	logic [ST_OUT:1]   valid_pipe_q;

	// the whole pipe moves unless the finished item is held by the sink
	assign adv       = !(valid_pipe_q[ST_OUT] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = valid_pipe_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_pipe_q <= '0;
		else if (adv)
			valid_pipe_q <= {valid_pipe_q[ST_OUT-1:1], in_valid};
	end

	// ---------------- s1: capture, dry tests ----------------
	swh_in_t item_s1;
	logic    dry_l_s1, dry_r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= in_data;
			dry_l_s1 <= in_data.height_left < dry_thr_q;
			dry_r_s1 <= in_data.height_right < dry_thr_q;
		end
	end

	// ---------------- s2: g*h and discharge ----------------
	swh_in_t item_s2;
	logic    dry_l_s2, dry_r_s2;
	q_t      gh_l_s2, gh_r_s2, q_l_s2, q_r_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2  <= item_s1;
			dry_l_s2 <= dry_l_s1;
			dry_r_s2 <= dry_r_s1;
			gh_l_s2  <= qmul(from_height(gravity_q), from_height(item_s1.height_left));
			gh_r_s2  <= qmul(from_height(gravity_q), from_height(item_s1.height_right));
			q_l_s2   <= qmul(item_s1.vel_x_left, from_height(item_s1.height_left));
			q_r_s2   <= qmul(item_s1.vel_x_right, from_height(item_s1.height_right));
		end
	end

	// celerities run in parallel with the momentum terms below
	logic [SQRT_BITS-1:0] root_l, root_r;

	swh_sqrt u_sqrt_l (.clk(clk), .en(adv), .x(gh_l_s2), .root(root_l));
	swh_sqrt u_sqrt_r (.clk(clk), .en(adv), .x(gh_r_s2), .root(root_r));

	// ---------------- s3: momentum products, jumps ----------------
	swh_in_t item_s3;
	logic    dry_l_s3, dry_r_s3;
	q_t      q_l_s3, q_r_s3, qu_l_s3, qu_r_s3, ghh_l_s3, ghh_r_s3, dh_s3, dq_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3  <= item_s2;
			dry_l_s3 <= dry_l_s2;
			dry_r_s3 <= dry_r_s2;
			q_l_s3   <= q_l_s2;
			q_r_s3   <= q_r_s2;
			qu_l_s3  <= qmul(q_l_s2, item_s2.vel_x_left);
			qu_r_s3  <= qmul(q_r_s2, item_s2.vel_x_right);
			ghh_l_s3 <= qmul(gh_l_s2, from_height(item_s2.height_left));
			ghh_r_s3 <= qmul(gh_r_s2, from_height(item_s2.height_right));
			dh_s3    <= qsub(from_height(item_s2.height_right),
			                 from_height(item_s2.height_left));
			dq_s3    <= qsub(q_r_s2, q_l_s2);
		end
	end

	// ---------------- s4: physical momentum flux ----------------
	swh_side_t side_s4, side_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.h_l   <= from_height(item_s3.height_left);
			side_s4.h_r   <= from_height(item_s3.height_right);
			side_s4.u_l   <= item_s3.vel_x_left;
			side_s4.u_r   <= item_s3.vel_x_right;
			side_s4.v_l   <= item_s3.vel_y_left;
			side_s4.v_r   <= item_s3.vel_y_right;
			side_s4.q_l   <= q_l_s3;
			side_s4.q_r   <= q_r_s3;
			side_s4.p_l   <= qadd(qu_l_s3, qmul(ghh_l_s3, Q_HALF));
			side_s4.p_r   <= qadd(qu_r_s3, qmul(ghh_r_s3, Q_HALF));
			side_s4.dh    <= dh_s3;
			side_s4.dq    <= dq_s3;
			side_s4.dry_l <= dry_l_s3;
			side_s4.dry_r <= dry_r_s3;
		end
	end

	swh_delay #(.W(SIDE_W), .N(ST_SQRT - 4)) u_dly_sqrt (
		.clk(clk), .en(adv), .din(side_s4), .dout(side_s8)
	);

	// ---------------- s9: wave speed bounds ----------------
	swh_side_t side_s9;
	q_t        c1_s9, c2_s9;
	q_t        s_l, s_r;

	assign s_l = q_t'(root_l);
	assign s_r = q_t'(root_r);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= side_s8;
			// a dry side takes the dry-bed speed u -/+ 2c
			if (side_s8.dry_l)
				c1_s9 <= qsub(side_s8.u_r, qadd(s_r, s_r));
			else
				c1_s9 <= qmin(qsub(side_s8.u_l, s_l), qsub(side_s8.u_r, s_r));
			if (side_s8.dry_r)
				c2_s9 <= qadd(side_s8.u_l, qadd(s_l, s_l));
			else
				c2_s9 <= qmax(qadd(side_s8.u_l, s_l), qadd(side_s8.u_r, s_r));
		end
	end

	// ---------------- s10: spread, CFL speed ----------------
	swh_side_t side_s10;
	q_t        c1_s10, c2_s10, den_s10, t1n_s10, du_l_s10, du_r_s10;
	logic [30:0] wave_s10;
	q_t        wave_w;

	assign wave_w = qmax(qabs(c1_s9), qabs(c2_s9));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s10 <= side_s9;
			c1_s10   <= c1_s9;
			c2_s10   <= c2_s9;
			den_s10  <= qsub(c2_s9, c1_s9);
			t1n_s10  <= qsub(qmin(c2_s9, Q_ZERO), qmin(c1_s9, Q_ZERO));
			du_l_s10 <= qsub(side_s9.u_l, c1_s9);
			du_r_s10 <= qsub(side_s9.u_r, c2_s9);
			wave_s10 <= wave_w[30:0];
		end
	end

	// ---------------- s11: cross products ----------------
	swh_side_t   side_s11;
	q_t          c1_s11, c2_s11, den_s11, t1n_s11, m1_s11, m2_s11, a_l_s11, a_r_s11;
	logic [30:0] wave_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s11 <= side_s10;
			c1_s11   <= c1_s10;
			c2_s11   <= c2_s10;
			den_s11  <= den_s10;
			t1n_s11  <= t1n_s10;
			wave_s11 <= wave_s10;
			m1_s11   <= qmul(c2_s10, qabs(c1_s10));
			m2_s11   <= qmul(c1_s10, qabs(c2_s10));
			a_l_s11  <= qmul(side_s10.h_l, du_l_s10);
			a_r_s11  <= qmul(side_s10.h_r, du_r_s10);
		end
	end

	// ---------------- s12: contact terms ----------------
	swh_side_t   side_s12;
	q_t          den_s12, t1n_s12, x_s12, cden_s12, m3_s12, m4_s12;
	logic [30:0] wave_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s12 <= side_s11;
			den_s12  <= den_s11;
			t1n_s12  <= t1n_s11;
			wave_s12 <= wave_s11;
			x_s12    <= qsub(m1_s11, m2_s11);
			cden_s12 <= qsub(a_r_s11, a_l_s11);
			m3_s12   <= qmul(c1_s11, a_r_s11);
			m4_s12   <= qmul(c2_s11, a_l_s11);
		end
	end

	// ---------------- s13: divider operands ----------------
	swh_side_t   side_s13, side_s21;
	q_t          den_s13, t1n_s13, t3n_s13, cden_s13, cnum_s13;
	logic [30:0] wave_s13;
	swh_mid_t    mid_s13, mid_s21;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s13 <= side_s12;
			den_s13  <= den_s12;
			t1n_s13  <= t1n_s12;
			wave_s13 <= wave_s12;
			t3n_s13  <= qmul(x_s12, Q_HALF);
			cden_s13 <= cden_s12;
			cnum_s13 <= qsub(m3_s12, m4_s12);
		end
	end

	assign mid_s13.den_zero = (den_s13 == Q_ZERO);
	assign mid_s13.cden_nz  = (cden_s13 != Q_ZERO);
	assign mid_s13.wave     = wave_s13;

	q_t t1_s21, t3_s21, qc_s21;

	swh_div u_div_t1 (.clk(clk), .en(adv), .num(t1n_s13), .den(den_s13), .quo(t1_s21));
	swh_div u_div_t3 (.clk(clk), .en(adv), .num(t3n_s13), .den(den_s13), .quo(t3_s21));
	swh_div u_div_qc (.clk(clk), .en(adv), .num(cnum_s13), .den(cden_s13), .quo(qc_s21));

	swh_delay #(.W(SIDE_W + MID_W), .N(DIV_LAT)) u_dly_div (
		.clk(clk), .en(adv), .din({side_s13, mid_s13}), .dout({side_s21, mid_s21})
	);

	// ---------------- s22: weights, transverse pick ----------------
	swh_side_t side_s22;
	swh_mid_t  mid_s22;
	q_t        t1_s22, t2_s22, t3_s22, sel_s22;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s22 <= side_s21;
			mid_s22  <= mid_s21;
			t1_s22   <= t1_s21;
			t2_s22   <= qsub(Q_ONE, t1_s21);
			t3_s22   <= t3_s21;
			// left value only for a real contact speed above epsilon
			sel_s22  <= (mid_s21.cden_nz && (qc_s21 > eps_q)) ? side_s21.v_l
			                                                   : side_s21.v_r;
		end
	end

	// ---------------- s23: HLL products ----------------
	swh_mid_t mid_s23;
	logic     both_dry_s23;
	q_t       sel_s23, ma_s23, mb_s23, mc_s23, md_s23, me_s23, mf_s23;

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s23      <= mid_s22;
			both_dry_s23 <= side_s22.dry_l & side_s22.dry_r;
			sel_s23      <= sel_s22;
			ma_s23       <= qmul(t1_s22, side_s22.q_r);
			mb_s23       <= qmul(t2_s22, side_s22.q_l);
			mc_s23       <= qmul(t3_s22, side_s22.dh);
			md_s23       <= qmul(t1_s22, side_s22.p_r);
			me_s23       <= qmul(t2_s22, side_s22.p_l);
			mf_s23       <= qmul(t3_s22, side_s22.dq);
		end
	end

	// ---------------- s24: HLL sums ----------------
	swh_mid_t mid_s24;
	logic     both_dry_s24;
	q_t       sel_s24, f1_s24, f2_s24;

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s24      <= mid_s23;
			both_dry_s24 <= both_dry_s23;
			sel_s24      <= sel_s23;
			f1_s24       <= qsub(qadd(ma_s23, mb_s23), mc_s23);
			f2_s24       <= qsub(qadd(md_s23, me_s23), mf_s23);
		end
	end

	// ---------------- s25: output register ----------------
	swh_out_t out_s25;
	logic     flux_zero;

	// both sides dry clears everything; a zero spread clears only the fluxes
	assign flux_zero = both_dry_s24 | mid_s24.den_zero;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s25.flux_mass       <= flux_zero ? Q_ZERO : f1_s24;
			out_s25.flux_momentum_x <= flux_zero ? Q_ZERO : f2_s24;
			out_s25.flux_momentum_y <= flux_zero ? Q_ZERO : qmul(f1_s24, sel_s24);
			out_s25.wave_speed      <= both_dry_s24 ? '0 : mid_s24.wave;
		end
	end

	assign out_data = out_s25;

endmodule
`default_nettype wire
